FILE: design/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants, tables and helper functions for the haversine
// great-circle distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int COORD_FRAC_BITS = 20;
  localparam int OUT_FRAC_BITS   = 10;

  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;
  localparam int RAD_W  = 24;
  localparam int DIST_W = 25;

  localparam logic [RAD_W-1:0]  RADIUS_RST = RAD_W'(6371000);
  localparam logic [DIST_W-1:0] DIST_MAX   = '1;

  // Q1.30 unsigned fixed point (31 bits), ONE = 2^30
  localparam int Q_W = 31;
  localparam logic [Q_W-1:0] Q_ONE       = 31'h4000_0000;
  localparam logic [Q_W-1:0] HALF_PI_Q   = 31'h6487_ED51;
  localparam logic [Q_W-1:0] CORDIC_GAIN = 31'h26DD_3B6A;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 31;
  localparam int SQ_W         = 62;
  localparam int CW           = 34;

  typedef logic signed [CW-1:0] cord_t;
  typedef logic [Q_W-1:0]       q_t;

  localparam cord_t ONE_C  = cord_t'(Q_ONE);
  localparam cord_t HP_C   = cord_t'(HALF_PI_Q);
  localparam cord_t GAIN_C = cord_t'(CORDIC_GAIN);

  localparam q_t ATAN_TAB [0:CORDIC_STEPS-1] = '{
    31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6, 31'h03FEAB76,
    31'h01FFD55B, 31'h00FFFAAA, 31'h007FFF55, 31'h003FFFEA, 31'h001FFFFD,
    31'h000FFFFF, 31'h0007FFFF, 31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF,
    31'h00007FFF, 31'h00003FFF, 31'h00001FFF, 31'h00000FFF, 31'h000007FF,
    31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F, 31'h0000003F,
    31'h0000001F, 31'h0000000F, 31'h00000007, 31'h00000003, 31'h00000001
  };

  // angle wrapping, degrees * 2^COORD_FRAC_BITS
  localparam int FULL_DEG = 360 << COORD_FRAC_BITS;
  localparam int HALF_DEG = 180 << COORD_FRAC_BITS;
  localparam int QTR_DEG  = 90 << COORD_FRAC_BITS;
  localparam int WIN_W    = 31;
  localparam int WR_W     = 34;
  localparam int WRAP_K   = ((1 << 30) / FULL_DEG) + 1;
  localparam int T_W      = $clog2(HALF_DEG + 1);

  localparam logic [T_W-1:0] HALF_T = T_W'(HALF_DEG);
  localparam logic [T_W-1:0] QTR_T  = T_W'(QTR_DEG);
  localparam logic signed [WR_W-1:0] HALF_W = WR_W'(HALF_DEG);

  // degrees to radians: product, then divide by 45 through a reciprocal
  localparam int PR_W = T_W + Q_W;
  localparam int MQ_W = 37;
  localparam int QE_W = 32;
  localparam logic [31:0] R45 = 32'(((64'd1 << MQ_W) + 64'd44) / 64'd45);

  // metres * radians to km: divide by 125 through a reciprocal
  localparam int NUM_W = RAD_W + Q_W;
  localparam int SH_D  = 32 - OUT_FRAC_BITS;
  localparam int PW    = RAD_W + OUT_FRAC_BITS;
  localparam int RDW   = PW - 6;
  localparam logic [RDW-1:0] RD = RDW'(((64'd1 << PW) + 64'd124) / 64'd125);
  localparam logic [NUM_W:0] RND_D = (NUM_W + 1)'(125) << (31 - OUT_FRAC_BITS);

  function automatic logic [T_W-1:0] wrap_abs(input logic signed [WIN_W-1:0] x);
    logic signed [WR_W-1:0] cand;
    logic signed [WR_W-1:0] r;
    r = '0;
    for (int k = -WRAP_K; k <= WRAP_K; k++) begin
      cand = WR_W'(x) - WR_W'(k * FULL_DEG);
      if (cand > -HALF_W && cand <= HALF_W) begin
        r = cand;
      end
    end
    return T_W'((r < 0) ? -r : r);
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic [2*Q_W-1:0] p;
    p = {31'd0, a} * {31'd0, b} + ((2*Q_W)'(1) << 29);
    return Q_W'(p >> 30);
  endfunction

  function automatic q_t clamp_q(input cord_t v, input cord_t hi);
    q_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > hi) begin
      r = Q_W'(hi);
    end else begin
      r = Q_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: design/great_circle_distance_top.sv
// ----------------------------------------------------------------------------
// great_circle_distance_top
// Haversine great-circle distance, fully pipelined, one pair per cycle unless stalled.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one pair of points per
// transaction: two latitudes and two longitudes in signed degrees with
// COORD_FRAC_BITS fraction bits. The result channel (out_valid/out_ready)
// returns the distance in km with OUT_FRAC_BITS fraction bits, saturated.
// cfg_wr_en/cfg_wr_data load the sphere radius in metres; write it only
// while the pipeline is empty.
// Throughput: one transaction per cycle while in_ready is high; the 106
// datapath stages are 7 of angle preparation, a 30-stage rotation CORDIC
// (four lanes side by side), 4 product stages, a 31-stage square root,
// a 30-stage vectoring CORDIC and 4 scaling stages, one step per stage,
// followed by the output register.
// Reset: radius returns to 6371000 m, all valid bits clear.
// Stall: a held result sits in the output register; one more result drops
// into a skid register, after which in_ready falls and the whole pipeline
// freezes until the receiver takes the output.
// ----------------------------------------------------------------------------
module great_circle_distance_top
  import gcd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [LAT_W-1:0] in_lat_first,
  input  logic signed [LON_W-1:0] in_lon_first,
  input  logic signed [LAT_W-1:0] in_lat_second,
  input  logic signed [LON_W-1:0] in_lon_second,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DIST_W-1:0]       out_distance_km,
  input  logic                    cfg_wr_en,
  input  logic [RAD_W-1:0]        cfg_wr_data
);

  localparam int NSTG    = 7 + CORDIC_STEPS + 4 + SQRT_STEPS + CORDIC_STEPS + 4;
  localparam int NX_LAST = 7 + CORDIC_STEPS + 3;
  localparam int DLAT_W  = LAT_W + 1;
  localparam int DLON_W  = LON_W + 1;

  logic                     en;
  logic [NSTG-1:0]          vld_r;
  logic [RAD_W-1:0]         radius_r;

  logic signed [DLAT_W-1:0] dlat_r;
  logic signed [DLON_W-1:0] dlon_r;
  logic signed [LAT_W-1:0]  lat1_r;
  logic signed [LAT_W-1:0]  lat2_r;

  logic [T_W-1:0]           w_c [0:3];
  logic [T_W-1:0]           t_r [0:3];
  logic                     neg1_c;
  logic                     neg2_c;
  logic [NX_LAST:2]         nx_r;

  cord_t                    rot_x [0:3];
  cord_t                    rot_y [0:3];

  q_t                       s_lat_r, s_lon_r, c1_r, c2_r;
  q_t                       sq_lat_r, sq_lon_r, c12_r;
  q_t                       t1_r, t2_r;
  logic signed [Q_W+1:0]    asum_c;
  q_t                       a_r;

  logic [SQ_W-1:0]          sq_res [0:1];

  cord_t                    vx_c [0:CORDIC_STEPS-1];
  cord_t                    vy_c [0:CORDIC_STEPS-1];
  cord_t                    vz_c [0:CORDIC_STEPS-1];
  cord_t                    vx_r [1:CORDIC_STEPS-1];
  cord_t                    vy_r [1:CORDIC_STEPS-1];
  cord_t                    vz_r [1:CORDIC_STEPS];

  q_t                       theta_r;
  logic [NUM_W-1:0]         num_r;
  logic [NUM_W:0]           numr_c;
  logic [PW-1:0]            pq_r;
  logic [PW-1:0]            pq6_r;
  logic [PW+RDW-1:0]        pd_r;

  logic [RDW-1:0]           qd_c;
  logic [PW:0]              q125_c;
  logic [RDW-1:0]           qf_c;
  logic [DIST_W-1:0]        dist_c;

  logic                     out_valid_r;
  logic [DIST_W-1:0]        out_dist_r;
  logic                     sk_valid_r;
  logic [DIST_W-1:0]        sk_dist_r;

  assign en       = !sk_valid_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // differences and raw latitudes
  always_ff @(posedge clk) begin
    if (en) begin
      dlat_r <= DLAT_W'(in_lat_second) - DLAT_W'(in_lat_first);
      dlon_r <= DLON_W'(in_lon_second) - DLON_W'(in_lon_first);
      lat1_r <= in_lat_first;
      lat2_r <= in_lat_second;
    end
  end

  // wrap to (-180, 180], magnitude, fold latitudes into [0, 90]
  always_comb begin
    w_c[0] = wrap_abs(WIN_W'(dlat_r));
    w_c[1] = wrap_abs(WIN_W'(dlon_r));
    w_c[2] = wrap_abs(WIN_W'(lat1_r));
    w_c[3] = wrap_abs(WIN_W'(lat2_r));
    neg1_c = w_c[2] > QTR_T;
    neg2_c = w_c[3] > QTR_T;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= w_c[0];
      t_r[1] <= w_c[1];
      t_r[2] <= neg1_c ? HALF_T - w_c[2] : w_c[2];
      t_r[3] <= neg2_c ? HALF_T - w_c[3] : w_c[3];
      nx_r   <= {nx_r[NX_LAST-1:2], neg1_c ^ neg2_c};
    end
  end

  // lanes: half dlat, half dlon, lat1, lat2
  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam int SH = (l < 2) ? COORD_FRAC_BITS + 2 : COORD_FRAC_BITS + 1;
    localparam logic [PR_W:0] RND = (l < 2) ? (PR_W + 1)'(90 << COORD_FRAC_BITS)
                                            : (PR_W + 1)'(45 << COORD_FRAC_BITS);
    logic [PR_W-1:0]   prod_r;
    logic [PR_W:0]     rsum_c;
    logic [MQ_W-1:0]   mq_r, mq5_r, mq6_r;
    logic [63:0]       plo_r;
    logic [MQ_W-1:0]   phi_r;
    logic [MQ_W+32:0]  qsum_c;
    logic [QE_W-1:0]   qe_r;
    logic [QE_W+5:0]   qe45_c;
    q_t                ang_r;
    cord_t             cx_c [0:CORDIC_STEPS-1];
    cord_t             cy_c [0:CORDIC_STEPS-1];
    cord_t             cz_c [0:CORDIC_STEPS-1];
    cord_t             cx_r [1:CORDIC_STEPS];
    cord_t             cy_r [1:CORDIC_STEPS];
    cord_t             cz_r [1:CORDIC_STEPS-1];

    assign rsum_c = (PR_W + 1)'(prod_r) + RND;
    assign qsum_c = {1'b0, phi_r, 32'd0} + (MQ_W + 33)'(plo_r);
    assign qe45_c = (QE_W + 6)'(qe_r) * (QE_W + 6)'(45);

    always_ff @(posedge clk) begin
      if (en) begin
        prod_r <= PR_W'(t_r[l]) * PR_W'(HALF_PI_Q);
        mq_r   <= MQ_W'(rsum_c >> SH);
        plo_r  <= 64'(mq_r[31:0]) * 64'(R45);
        phi_r  <= MQ_W'(mq_r[MQ_W-1:32]) * MQ_W'(R45);
        mq5_r  <= mq_r;
        qe_r   <= QE_W'(qsum_c >> MQ_W);
        mq6_r  <= mq5_r;
        ang_r  <= (qe45_c > (QE_W + 6)'(mq6_r)) ? Q_W'(qe_r - 1'b1) : Q_W'(qe_r);
      end
    end

    assign cx_c[0] = GAIN_C;
    assign cy_c[0] = '0;
    assign cz_c[0] = cord_t'(ang_r);

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      cord_t dx, dy;
      if (i > 0) begin : g_link
        assign cx_c[i] = cx_r[i];
        assign cy_c[i] = cy_r[i];
        assign cz_c[i] = cz_r[i];
      end
      assign dx = cy_c[i] >>> i;
      assign dy = cx_c[i] >>> i;
      always_ff @(posedge clk) begin
        if (en) begin
          if (!cz_c[i][CW-1]) begin
            cx_r[i+1] <= cx_c[i] - dx;
            cy_r[i+1] <= cy_c[i] + dy;
          end else begin
            cx_r[i+1] <= cx_c[i] + dx;
            cy_r[i+1] <= cy_c[i] - dy;
          end
        end
      end
      if (i < CORDIC_STEPS - 1) begin : g_z
        always_ff @(posedge clk) begin
          if (en) begin
            if (!cz_c[i][CW-1]) begin
              cz_r[i+1] <= cz_c[i] - cord_t'(ATAN_TAB[i]);
            end else begin
              cz_r[i+1] <= cz_c[i] + cord_t'(ATAN_TAB[i]);
            end
          end
        end
      end
    end

    assign rot_x[l] = cx_r[CORDIC_STEPS];
    assign rot_y[l] = cy_r[CORDIC_STEPS];
  end

  // haversine term
  always_comb begin
    if (nx_r[NX_LAST]) begin
      asum_c = $signed({2'b00, t1_r}) - $signed({2'b00, t2_r});
    end else begin
      asum_c = $signed({2'b00, t1_r}) + $signed({2'b00, t2_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_lat_r  <= clamp_q(rot_y[0], ONE_C);
      s_lon_r  <= clamp_q(rot_y[1], ONE_C);
      c1_r     <= clamp_q(rot_x[2], ONE_C);
      c2_r     <= clamp_q(rot_x[3], ONE_C);
      sq_lat_r <= qmul(s_lat_r, s_lat_r);
      sq_lon_r <= qmul(s_lon_r, s_lon_r);
      c12_r    <= qmul(c1_r, c2_r);
      t1_r     <= sq_lat_r;
      t2_r     <= qmul(c12_r, sq_lon_r);
      if (asum_c < 0) begin
        a_r <= '0;
      end else if (asum_c > $signed({2'b00, Q_ONE})) begin
        a_r <= Q_ONE;
      end else begin
        a_r <= asum_c[Q_W-1:0];
      end
    end
  end

  // square roots of a and 1-a, one result bit per stage
  for (genvar j = 0; j < 2; j++) begin : g_sqrt
    logic [SQ_W-1:0] n_c [0:SQRT_STEPS-1];
    logic [SQ_W-1:0] r_c [0:SQRT_STEPS-1];
    logic [SQ_W-1:0] n_r [1:SQRT_STEPS-1];
    logic [SQ_W-1:0] r_r [1:SQRT_STEPS];

    if (j == 0) begin : g_u
      assign n_c[0] = SQ_W'({a_r, 30'd0});
    end else begin : g_v
      assign n_c[0] = SQ_W'({Q_ONE - a_r, 30'd0});
    end
    assign r_c[0] = '0;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_bit
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [SQ_W-1:0] trial_c;
      if (k > 0) begin : g_link
        assign n_c[k] = n_r[k];
        assign r_c[k] = r_r[k];
      end
      assign trial_c = r_c[k] + BIT;
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[k+1] <= (n_c[k] >= trial_c) ? (r_c[k] >> 1) + BIT : r_c[k] >> 1;
        end
      end
      if (k < SQRT_STEPS - 1) begin : g_n
        always_ff @(posedge clk) begin
          if (en) begin
            n_r[k+1] <= (n_c[k] >= trial_c) ? n_c[k] - trial_c : n_c[k];
          end
        end
      end
    end

    assign sq_res[j] = r_r[SQRT_STEPS];
  end

  // atan2(u, v) by vectoring
  assign vx_c[0] = cord_t'(sq_res[1][Q_W-1:0]);
  assign vy_c[0] = cord_t'(sq_res[0][Q_W-1:0]);
  assign vz_c[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    cord_t dx, dy;
    if (i > 0) begin : g_link
      assign vx_c[i] = vx_r[i];
      assign vy_c[i] = vy_r[i];
      assign vz_c[i] = vz_r[i];
    end
    assign dx = vy_c[i] >>> i;
    assign dy = vx_c[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy_c[i][CW-1]) begin
          vz_r[i+1] <= vz_c[i] + cord_t'(ATAN_TAB[i]);
        end else begin
          vz_r[i+1] <= vz_c[i] - cord_t'(ATAN_TAB[i]);
        end
      end
    end
    if (i < CORDIC_STEPS - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          if (!vy_c[i][CW-1]) begin
            vx_r[i+1] <= vx_c[i] + dx;
            vy_r[i+1] <= vy_c[i] - dy;
          end else begin
            vx_r[i+1] <= vx_c[i] - dx;
            vy_r[i+1] <= vy_c[i] + dy;
          end
        end
      end
    end
  end

  // scale by radius, convert to km
  assign numr_c = (NUM_W + 1)'(num_r) + RND_D;

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= clamp_q(vz_r[CORDIC_STEPS], HP_C);
      num_r   <= NUM_W'(radius_r) * NUM_W'(theta_r);
      pq_r    <= PW'(numr_c >> SH_D);
      pd_r    <= (PW + RDW)'(pq_r) * (PW + RDW)'(RD);
      pq6_r   <= pq_r;
    end
  end

  always_comb begin
    qd_c   = RDW'(pd_r >> PW);
    q125_c = (PW + 1)'(qd_c) * (PW + 1)'(125);
    qf_c   = (q125_c > (PW + 1)'(pq6_r)) ? qd_c - 1'b1 : qd_c;
    if ((RDW + DIST_W)'(qf_c) > (RDW + DIST_W)'(DIST_MAX)) begin
      dist_c = DIST_MAX;
    end else begin
      dist_c = DIST_W'(qf_c);
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (sk_valid_r) begin
        out_valid_r <= 1'b1;
        sk_valid_r  <= 1'b0;
      end else begin
        out_valid_r <= vld_r[NSTG-1];
      end
    end else if (en && vld_r[NSTG-1]) begin
      sk_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_dist_r <= sk_valid_r ? sk_dist_r : dist_c;
    end else if (en) begin
      sk_dist_r <= dist_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_distance_km = out_dist_r;

endmodule

FILE: design/gcd_checker.sv
// ----------------------------------------------------------------------------
// gcd_checker
// Port-level checks for great_circle_distance_top, bound to the top level.
// ----------------------------------------------------------------------------
module gcd_checker
  import gcd_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic signed [LAT_W-1:0] in_lat_first,
  input logic signed [LON_W-1:0] in_lon_first,
  input logic signed [LAT_W-1:0] in_lat_second,
  input logic signed [LON_W-1:0] in_lon_second,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [DIST_W-1:0]       out_distance_km,
  input logic                    cfg_wr_en,
  input logic [RAD_W-1:0]        cfg_wr_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction withdrawn");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_km))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not empty after reset");

  a_bp_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked with no result waiting");

  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input blocked without receiver stall");

endmodule

bind great_circle_distance_top gcd_checker u_gcd_checker (.*);
